// ===== hw/rtl/wcta_pkg.sv =====
// shared types and constants of the wall column texel address block
`default_nettype none

package wcta_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int TEX_W   = 4;
  localparam int TCOL_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int NUM_W   = 26;
  localparam int DEN_W   = 16;
  localparam int QUO_W   = 10;
  localparam int IDX_W   = 20;
  localparam int BITS_PER_STAGE = 2;

  localparam logic [1:0] REG_OVERRIDE   = 2'd0;
  localparam logic [1:0] REG_TEX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd2;

  localparam logic [TEX_W-1:0] TEX_DIR_BASE = 4'd9;
  localparam logic [TEX_W-1:0] TEX_OVERRIDE = 4'd8;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [TEX_W-1:0]  texnum;
    logic [TCOL_W-1:0] tcol;
  } wcta_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wcta_div.sv =====
// pipelined restoring divider for the texture row, two quotient bits per stage
`default_nettype none

module wcta_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wcta_pkg::NUM_W-1:0]  in_num,
  input  logic [wcta_pkg::DEN_W-1:0]  in_den,
  input  wcta_pkg::wcta_side_t        in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wcta_pkg::QUO_W-1:0]  out_quo,
  output wcta_pkg::wcta_side_t        out_side
);
  import wcta_pkg::*;

  localparam int NST = QUO_W / BITS_PER_STAGE;

  logic             v    [NST];
  logic             en   [NST+1];
  logic [NUM_W-1:0] rem  [NST-1];
  logic [DEN_W-1:0] den  [NST-1];
  logic [QUO_W-1:0] quo  [NST];
  wcta_side_t       side [NST];

  assign en[NST] = out_ready;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] rem_out;
    logic [NUM_W-1:0] trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_out;
    wcta_side_t       side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v[k-1];
      assign rem_in  = rem[k-1];
      assign den_in  = den[k-1];
      assign quo_in  = quo[k-1];
      assign side_in = side[k-1];
    end

    assign en[k] = !v[k] || en[k+1];

    always_comb begin
      rem_out = rem_in;
      quo_out = quo_in;
      trial   = '0;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        trial = {{(NUM_W-DEN_W){1'b0}}, den_in} << (QUO_W - 1 - k * BITS_PER_STAGE - j);
        if (rem_out >= trial) begin
          rem_out = rem_out - trial;
          quo_out[QUO_W - 1 - k * BITS_PER_STAGE - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo[k]  <= quo_out;
        side[k] <= side_in;
      end
    end

    if (k < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= rem_out;
          den[k] <= den_in;
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];
  assign out_quo   = quo[NST-1];
  assign out_side  = side[NST-1];

endmodule

`default_nettype wire

// ===== hw/rtl/wall_column_texel_address.sv =====
// top level of the wall column texel address pipeline
//
// one pixel request enters on the s_ group per transaction; a pixel that
// lies on the wall span gives one result on the m_ group, any other pixel
// (zero height, above or below the wall, on a row past the screen height) gives none
// configuration is to be written on the cfg_ port only while the pipeline
// is empty, which the block does not enforce: index 0 override flag,
// 1 texture width, 2 texture height; throughput: one transaction per cycle
// on both sides while the receiver does not stall; registered in order:
// span check and texture choice, two multiplies, five stages of the
// row divider (two quotient bits each) and the index multiply-add
// each stage holds its own valid bit and moves when the next one is free,
// so empty stages are filled while the receiver stalls and nothing is lost
// reset clears all stages and sets override 0, width 64, height 64
`default_nettype none

module wall_column_texel_address #(
  parameter int SCREEN_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // column, row, hit_x, hit_y, wall_height, wall_type
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_column, out_row, texture_number, texel_index
  output logic [47:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);
  import wcta_pkg::*;

  localparam logic [12:0] SH = 13'(SCREEN_HEIGHT);

  function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_W-1:0] val);
    if (val == '0) return 11'd1;
    if (val > 11'd1024) return 11'd1024;
    return val;
  endfunction

  logic              override_tex;
  logic [SIZE_W-1:0] tex_cols;
  logic [SIZE_W-1:0] tex_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      override_tex <= 1'b0;
      tex_cols     <= 11'd64;
      tex_rows     <= 11'd64;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_OVERRIDE:   override_tex <= cfg_wdata[0];
        REG_TEX_WIDTH:  tex_cols     <= size_sat(cfg_wdata);
        REG_TEX_HEIGHT: tex_rows     <= size_sat(cfg_wdata);
        default: ;
      endcase
    end
  end

  // input unpack
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [15:0]      in_hx;
  logic [15:0]      in_hy;
  logic [15:0]      in_hgt;
  logic [3:0]       in_type;

  assign in_col  = s_tdata[9:0];
  assign in_row  = s_tdata[18:10];
  assign in_hx   = s_tdata[34:19];
  assign in_hy   = s_tdata[50:35];
  assign in_hgt  = s_tdata[66:51];
  assign in_type = s_tdata[70:67];

  // stage a: span check, texture number, column selector
  logic signed [17:0] span_t;
  logic signed [17:0] top_c;
  logic signed [17:0] diff_c;
  logic               draw_c;
  logic signed [8:0]  fx;
  logic signed [8:0]  fy;
  logic signed [8:0]  nfx;
  logic               ge_fx;
  logic               ge_nfx;
  logic [1:0]         quad;
  logic [TEX_W-1:0]   tex_c;
  logic signed [7:0]  cx;
  logic signed [7:0]  cy;
  logic [8:0]         ax;
  logic [8:0]         ay;
  logic signed [7:0]  sel_c;

  always_comb begin
    span_t = $signed({5'd0, SH}) - $signed({2'd0, in_hgt});
    top_c  = (span_t + $signed({17'd0, span_t[17]})) >>> 1;
    diff_c = $signed({9'd0, in_row}) - top_c;
    draw_c = (in_hgt != '0) && !diff_c[17] && (diff_c[16:0] < {1'b0, in_hgt})
             && ({4'd0, in_row} < SH);

    fx     = 9'sd128 - $signed({1'b0, in_hx[7:0]});
    fy     = 9'sd128 - $signed({1'b0, in_hy[7:0]});
    nfx    = -fx;
    ge_fx  = fy >= fx;
    ge_nfx = fy >= nfx;
    if (ge_fx && ge_nfx) quad = 2'd0;
    else if (!ge_fx && ge_nfx) quad = 2'd1;
    else if (ge_fx && !ge_nfx) quad = 2'd2;
    else quad = 2'd3;

    if (in_type == '0) tex_c = TEX_DIR_BASE + {2'd0, quad};
    else if (override_tex) tex_c = TEX_OVERRIDE;
    else if (in_type > 4'd8) tex_c = 4'd7;
    else tex_c = in_type - 4'd1;

    cx    = $signed(in_hx[7:0]);
    cy    = $signed(in_hy[7:0]);
    ax    = cx[7] ? (9'd0 - {1'b1, cx}) : {1'b0, cx};
    ay    = cy[7] ? (9'd0 - {1'b1, cy}) : {1'b0, cy};
    sel_c = (ax > ay) ? cx : cy;
  end

  logic              a_valid;
  logic              b_valid;
  logic              en_a;
  logic              en_b;
  logic              en_o;
  logic              div_in_ready;
  logic              div_out_valid;
  logic [QUO_W-1:0]  div_quo;
  wcta_side_t        div_side;
  wcta_side_t        div_in_side;

  logic [COL_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_row;
  logic [TEX_W-1:0]  a_tex;
  logic [15:0]       a_diff;
  logic [15:0]       a_hgt;
  logic signed [7:0] a_sel;

  assign en_a     = !a_valid || en_b;
  assign en_b     = !b_valid || div_in_ready;
  assign en_o     = !m_tvalid || m_tready;
  assign s_tready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= s_tvalid && draw_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_col  <= in_col;
      a_row  <= in_row;
      a_tex  <= tex_c;
      a_diff <= diff_c[15:0];
      a_hgt  <= in_hgt;
      a_sel  <= sel_c;
    end
  end

  // stage b: column and row products
  logic signed [19:0] prod_col_c;
  logic [26:0]        prod_row_c;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic [TEX_W-1:0]   b_tex;
  logic [15:0]        b_hgt;
  logic signed [19:0] b_prod_col;
  logic [NUM_W-1:0]   b_prod_row;

  assign prod_col_c = a_sel * $signed({1'b0, tex_cols});
  assign prod_row_c = a_diff * tex_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_col      <= a_col;
      b_row      <= a_row;
      b_tex      <= a_tex;
      b_hgt      <= a_hgt;
      b_prod_col <= prod_col_c;
      b_prod_row <= prod_row_c[NUM_W-1:0];
    end
  end

  // texture column: divide by 256 toward zero, wrap negatives by the width
  logic signed [19:0] pcol_adj;
  logic signed [11:0] tcol_q;
  logic signed [11:0] tcol_w;

  always_comb begin
    pcol_adj = b_prod_col + (b_prod_col[19] ? 20'sd255 : 20'sd0);
    tcol_q   = pcol_adj[19:8];
    tcol_w   = tcol_q[11] ? (tcol_q + $signed({1'b0, tex_cols})) : tcol_q;
    div_in_side.column = b_col;
    div_in_side.row    = b_row;
    div_in_side.texnum = b_tex;
    div_in_side.tcol   = tcol_w[TCOL_W-1:0];
  end

  wcta_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (div_in_ready),
    .in_num    (b_prod_row),
    .in_den    (b_hgt),
    .in_side   (div_in_side),
    .out_valid (div_out_valid),
    .out_ready (en_o),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // output stage: index stays below width times height by construction
  logic [20:0]      idx_prod;
  logic [20:0]      idx_sum;
  logic [COL_W-1:0] o_col;
  logic [ROW_W-1:0] o_row;
  logic [TEX_W-1:0] o_tex;
  logic [IDX_W-1:0] o_idx;

  assign idx_prod = div_quo * tex_cols;
  assign idx_sum  = idx_prod + {11'd0, div_side.tcol};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_o) begin
      m_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_col <= div_side.column;
      o_row <= div_side.row;
      o_tex <= div_side.texnum;
      o_idx <= idx_sum[IDX_W-1:0];
    end
  end

  assign m_tdata = {5'd0, o_idx, o_tex, o_row, o_col};

endmodule

`default_nettype wire
